@@ src/vfv_pkg.sv @@
// ----------------------------------------------------------------------------
// vfv_pkg
// Shared types and constants for the voxel face visibility block.
// ----------------------------------------------------------------------------
`default_nettype none

package vfv_pkg;

    localparam int GRID_X_DEF = 16;
    localparam int GRID_Y_DEF = 256;
    localparam int GRID_Z_DEF = 16;

    localparam int POS_X_W = 4;
    localparam int POS_Y_W = 8;
    localparam int POS_Z_W = 4;
    localparam int COORD_W = 8;
    localparam int CELL_W  = 2;
    localparam int MASK_W  = 6;

    typedef enum logic [CELL_W-1:0] {
        KIND_EMPTY       = 2'd0,
        KIND_SOLID       = 2'd1,
        KIND_TRANSPARENT = 2'd2,
        KIND_DESTROYED   = 2'd3
    } kind_t;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        DIR_NEG_Z = 3'd0,
        DIR_POS_Z = 3'd1,
        DIR_NEG_X = 3'd2,
        DIR_POS_X = 3'd3,
        DIR_NEG_Y = 3'd4,
        DIR_POS_Y = 3'd5
    } dir_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_QUERY = 2'd2,
        ST_DONE  = 2'd3
    } state_t;

endpackage

`default_nettype wire

@@ src/voxel_face_visibility.sv @@
// ----------------------------------------------------------------------------
// voxel_face_visibility
// Voxel grid store with a six-face visibility query per cell.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole cell store to empty, one cell per
// clock, and holds in_ready low until the sweep ends. A write word is taken
// and the block is ready again on the next cycle. A query word reads the cell
// and its six neighbours through the single memory port, one read per cycle,
// so in_ready stays low from acceptance through the reads and the done state,
// longer still while an earlier mask waits to be taken; the mask stands in an
// output register and later writes proceed while it waits to be taken. Face
// bits run -z, +z, -x, +x, -y, +y.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_face_visibility #(
    parameter int GRID_X = vfv_pkg::GRID_X_DEF,
    parameter int GRID_Y = vfv_pkg::GRID_Y_DEF,
    parameter int GRID_Z = vfv_pkg::GRID_Z_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         op,
    input  wire logic [vfv_pkg::POS_X_W-1:0]  pos_x,
    input  wire logic [vfv_pkg::POS_Y_W-1:0]  pos_y,
    input  wire logic [vfv_pkg::POS_Z_W-1:0]  pos_z,
    input  wire logic [vfv_pkg::CELL_W-1:0]   cell_kind,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [vfv_pkg::MASK_W-1:0]   face_mask
);

    localparam int SPAN_X = 1 << vfv_pkg::POS_X_W;
    localparam int SPAN_Y = 1 << vfv_pkg::POS_Y_W;
    localparam int SPAN_Z = 1 << vfv_pkg::POS_Z_W;
    localparam int XN     = (GRID_X < SPAN_X) ? GRID_X : SPAN_X;
    localparam int YN     = (GRID_Y < SPAN_Y) ? GRID_Y : SPAN_Y;
    localparam int ZN     = (GRID_Z < SPAN_Z) ? GRID_Z : SPAN_Z;
    localparam int XW     = $clog2(XN);
    localparam int YW     = $clog2(YN);
    localparam int ZW     = $clog2(ZN);
    localparam int AW     = XW + YW + ZW;

    localparam logic [vfv_pkg::COORD_W-1:0] LIM_X = vfv_pkg::COORD_W'(XN - 1);
    localparam logic [vfv_pkg::COORD_W-1:0] LIM_Y = vfv_pkg::COORD_W'(YN - 1);
    localparam logic [vfv_pkg::COORD_W-1:0] LIM_Z = vfv_pkg::COORD_W'(ZN - 1);
    localparam logic [2:0] STEP_LAST = 3'd7;
    localparam logic [2:0] STEP_CTR  = 3'd1;

    vfv_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [2:0]      step_reg, step_next;
    logic [vfv_pkg::POS_X_W-1:0] x_reg, x_next;
    logic [vfv_pkg::POS_Y_W-1:0] y_reg, y_next;
    logic [vfv_pkg::POS_Z_W-1:0] z_reg, z_next;
    vfv_pkg::kind_t  kind_reg, kind_next;
    logic [vfv_pkg::MASK_W-1:0] mask_reg, mask_next;
    logic            ok_reg, ok_next;
    logic            out_valid_reg, out_valid_next;
    logic [vfv_pkg::MASK_W-1:0] face_mask_reg, face_mask_next;

    logic            accept;
    logic            port_in_grid;
    logic            out_free;
    logic [vfv_pkg::MASK_W-1:0] mask_final;

    vfv_pkg::dir_t   dir;
    logic [2:0]      dir_code;
    logic [vfv_pkg::COORD_W-1:0] coord;
    logic [vfv_pkg::COORD_W-1:0] lim;
    logic [vfv_pkg::COORD_W-1:0] coord_new;
    logic            dir_neg;
    logic            nb_ok;
    logic [vfv_pkg::POS_X_W-1:0] nx;
    logic [vfv_pkg::POS_Y_W-1:0] ny;
    logic [vfv_pkg::POS_Z_W-1:0] nz;
    logic [AW-1:0]   unit_addr;

    logic                         ram_we;
    logic [AW-1:0]                ram_addr;
    logic [vfv_pkg::CELL_W-1:0]   ram_wdata;
    logic [vfv_pkg::CELL_W-1:0]   ram_rdata;
    logic [2:0]                   bit_idx;

    assign accept       = in_valid && in_ready;
    assign out_free     = !out_valid_reg || out_ready;
    assign port_in_grid = (32'(pos_x) < XN) && (32'(pos_y) < YN) && (32'(pos_z) < ZN);
    assign in_ready     = (state_reg == vfv_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign face_mask    = face_mask_reg;
    assign mask_final   = (kind_reg == vfv_pkg::KIND_SOLID ||
                           kind_reg == vfv_pkg::KIND_TRANSPARENT) ? mask_reg : '0;
    assign bit_idx      = step_reg - 3'd2;

    // shared neighbour step: one axis, one increment or decrement, one bound check
    assign dir_code = step_reg - 3'd1;
    assign dir      = vfv_pkg::dir_t'(dir_code);
    assign dir_neg  = !dir_code[0];
    assign coord_new = dir_neg ? (coord - vfv_pkg::COORD_W'(1))
                               : (coord + vfv_pkg::COORD_W'(1));

    always_comb
    begin
        unique case (dir)
            vfv_pkg::DIR_NEG_Z, vfv_pkg::DIR_POS_Z:
            begin
                coord = vfv_pkg::COORD_W'(z_reg);
                lim   = LIM_Z;
            end
            vfv_pkg::DIR_NEG_X, vfv_pkg::DIR_POS_X:
            begin
                coord = vfv_pkg::COORD_W'(x_reg);
                lim   = LIM_X;
            end
            vfv_pkg::DIR_NEG_Y, vfv_pkg::DIR_POS_Y:
            begin
                coord = vfv_pkg::COORD_W'(y_reg);
                lim   = LIM_Y;
            end
            default:
            begin
                coord = vfv_pkg::COORD_W'(z_reg);
                lim   = LIM_Z;
            end
        endcase
    end

    always_comb
    begin
        nx    = x_reg;
        ny    = y_reg;
        nz    = z_reg;
        nb_ok = 1'b0;
        unique case (dir)
            vfv_pkg::DIR_NEG_Z, vfv_pkg::DIR_POS_Z:
            begin
                nz    = coord_new[vfv_pkg::POS_Z_W-1:0];
                nb_ok = dir_neg ? (coord != '0) : (coord != lim);
            end
            vfv_pkg::DIR_NEG_X, vfv_pkg::DIR_POS_X:
            begin
                nx    = coord_new[vfv_pkg::POS_X_W-1:0];
                nb_ok = dir_neg ? (coord != '0) : (coord != lim);
            end
            vfv_pkg::DIR_NEG_Y, vfv_pkg::DIR_POS_Y:
            begin
                ny    = coord_new[vfv_pkg::POS_Y_W-1:0];
                nb_ok = dir_neg ? (coord != '0) : (coord != lim);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    assign unit_addr = {nx[XW-1:0], ny[YW-1:0], nz[ZW-1:0]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vfv_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == '1)
                begin
                    state_next = vfv_pkg::ST_IDLE;
                end
            end
            vfv_pkg::ST_IDLE:
            begin
                if (accept && vfv_pkg::op_t'(op) == vfv_pkg::OP_QUERY)
                begin
                    state_next = port_in_grid ? vfv_pkg::ST_QUERY : vfv_pkg::ST_DONE;
                end
            end
            vfv_pkg::ST_QUERY:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = vfv_pkg::ST_DONE;
                end
            end
            vfv_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = vfv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vfv_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        step_next      = '0;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        kind_next      = kind_reg;
        mask_next      = mask_reg;
        ok_next        = nb_ok;
        out_valid_next = out_valid_reg && !out_ready;
        face_mask_next = face_mask_reg;
        ram_we         = 1'b0;
        ram_addr       = unit_addr;
        ram_wdata      = vfv_pkg::KIND_EMPTY;
        unique case (state_reg)
            vfv_pkg::ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            vfv_pkg::ST_IDLE:
            begin
                ram_addr  = {pos_x[XW-1:0], pos_y[YW-1:0], pos_z[ZW-1:0]};
                ram_wdata = cell_kind;
                ram_we    = accept && vfv_pkg::op_t'(op) == vfv_pkg::OP_WRITE
                            && port_in_grid;
                if (accept)
                begin
                    x_next    = pos_x;
                    y_next    = pos_y;
                    z_next    = pos_z;
                    kind_next = vfv_pkg::KIND_EMPTY;
                    mask_next = '0;
                end
            end
            vfv_pkg::ST_QUERY:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == STEP_CTR)
                begin
                    kind_next = vfv_pkg::kind_t'(ram_rdata);
                end
                else if (step_reg > STEP_CTR)
                begin
                    mask_next[bit_idx] = !ok_reg ||
                        vfv_pkg::kind_t'(ram_rdata) != vfv_pkg::KIND_SOLID;
                end
            end
            vfv_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    face_mask_next = mask_final;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vfv_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        kind_reg      <= kind_next;
        mask_reg      <= mask_next;
        ok_reg        <= ok_next;
        face_mask_reg <= face_mask_next;
    end

    vfv_cell_ram #(
        .ADDR_W (AW)
    ) u_cell_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

`ifndef NO_ASSERTIONS
    a_no_word_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vfv_pkg::ST_CLEAR) |-> (!in_ready && !out_valid))
        else $error("word accepted or shown during store clear");

    a_query_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vfv_pkg::ST_QUERY && step_reg == STEP_LAST)
        |=> (state_reg == vfv_pkg::ST_DONE))
        else $error("query sequence did not finish after last read");

    a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && vfv_pkg::op_t'(op) == vfv_pkg::OP_WRITE)
        |=> (state_reg == vfv_pkg::ST_IDLE && in_ready))
        else $error("write word held the block busy");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == vfv_pkg::ST_DONE))
        else $error("result raised outside the done state");
`endif

endmodule

`default_nettype wire

@@ src/vfv_cell_ram.sv @@
// ----------------------------------------------------------------------------
// vfv_cell_ram
// Single-port cell store: one write or one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vfv_cell_ram #(
    parameter int ADDR_W = vfv_pkg::POS_X_W + vfv_pkg::POS_Y_W + vfv_pkg::POS_Z_W
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [ADDR_W-1:0]           addr,
    input  wire logic [vfv_pkg::CELL_W-1:0]  wdata,
    output logic      [vfv_pkg::CELL_W-1:0]  rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [vfv_pkg::CELL_W-1:0] mem [DEPTH];
    logic [vfv_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
